>>> rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared sizes, register indexes and storage types of the byterun1
// planar-to-chunky decoder
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int PLANE_COUNT = 8;
  localparam int MAX_BANDS   = 3;

  // bytes of one plane row at the widest image
  localparam int ROW_MAX = 2 * ((MAX_WIDTH + 15) / 16);
  localparam int ROW_AW  = $clog2(ROW_MAX);
  localparam int RS_W    = $clog2(ROW_MAX + 1);
  localparam int PLANE_AW = $clog2(PLANE_COUNT);

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 10;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DEEP_COLOR  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_COMPRESSED  = 2'd2;

  // one store entry: byte g of every plane, lane p is plane p
  typedef logic [PLANE_COUNT-1:0][7:0] plane_word_t;

endpackage

>>> rtl/core/byterun1_planar_to_chunky_decoder_top.sv
// ----------------------------------------------------------------------------
// byterun1_planar_to_chunky_decoder_top
// ByteRun1 body decoder that fills eight plane rows and emits each band row
// as groups of up to eight chunky pixels
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) takes one body byte per word,
//   start_image_i set on a word clears position, decoder phase and error
//   output channel (out_valid_o / out_ready_i) gives one group of up to 8 pixels,
//   or one error word, per handshake
//   configuration is a plain write port, written while the block is idle
// timing
//   a raw or literal byte is one store write, a control byte none, and the
//   byte of a repeat run makes as many store writes as the run is long: one
//   store write per cycle through the single write port, paused by emission
//   the byte that completes a band's eighth plane starts emission: S_EMIT_RD
//   reads the plane store's one read port into a registered word, then the
//   output register takes one group per cycle while the receiver takes them,
//   ceil(width/8) groups; an error word loads once the output is free
// reset and stall
//   reset clears position, phase and error and sets width 512, one band,
//   compression on; the plane store needs no clearing
//   a stalled receiver holds the output register; emission waits on it,
//   input is taken again once the block is back in its idle state
// ----------------------------------------------------------------------------
module byterun1_planar_to_chunky_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [bpc_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [bpc_pkg::CFG_DW-1:0] cfg_data_i,
  // byte input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       start_image_i,
  // pixel output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [63:0]                pixel_group_o,
  output logic [5:0]                 group_index_o,
  output logic [3:0]                 pixel_count_o,
  output logic [1:0]                 band_index_o,
  output logic                       last_in_row_o,
  output logic                       decode_error_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_ERR,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_LITERAL,
    PH_REPEAT
  } phase_e;

  localparam int AW  = bpc_pkg::ROW_AW;
  localparam int RW  = bpc_pkg::RS_W;
  localparam int PW  = bpc_pkg::PLANE_AW;

  // configuration registers
  logic [9:0] width_q, width_d;
  logic       deep_q, deep_d;
  logic       comp_q, comp_d;

  // decoder state
  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [7:0] run_q, run_d;
  logic [PW-1:0] plane_q, plane_d;
  logic [AW-1:0] bp_q, bp_d;
  logic [1:0] band_q, band_d;
  logic       err_q, err_d;

  // repeat run and emission bookkeeping
  logic [7:0]    rem_q, rem_d;
  logic [7:0]    byte_q, byte_d;
  logic          ret_run_q, ret_run_d;
  logic [1:0]    ebnd_q, ebnd_d;
  logic [AW-1:0] grp_q, grp_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] pix_q, pix_d;
  logic [5:0]  gidx_q, gidx_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  oband_q, oband_d;
  logic        last_q, last_d;
  logic        derr_q, derr_d;

  // plane store: one entry per byte position, one byte lane per plane
  bpc_pkg::plane_word_t mem_q [bpc_pkg::ROW_MAX];
  bpc_pkg::plane_word_t rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [PW-1:0] mem_lane;
  logic [7:0]    mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // derived geometry
  logic [9:0]    eff_w;
  logic [10:0]   wsum_rs;
  logic [10:0]   wsum_gr;
  logic [RW-1:0] rs;
  logic [RW-1:0] ngroups;
  logic [1:0]    bcnt;

  always_comb begin
    if (width_q == 10'd0) begin
      eff_w = 10'd1;
    end else if (width_q > 10'(bpc_pkg::MAX_WIDTH)) begin
      eff_w = 10'(bpc_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    wsum_rs = 11'(eff_w) + 11'd15;
    wsum_gr = 11'(eff_w) + 11'd7;
    rs      = RW'((wsum_rs >> 4) << 1);
    ngroups = RW'(wsum_gr >> 3);
    bcnt    = deep_q ? 2'(bpc_pkg::MAX_BANDS) : 2'd1;
  end

  // group formatting from the registered store word
  logic [10:0] px_left;
  logic [3:0]  grp_cnt;
  logic [63:0] grp_pix;
  logic        grp_last;

  always_comb begin
    px_left = 11'(eff_w) - {grp_q, 3'b000};
    grp_cnt = (px_left > 11'd8) ? 4'd8 : px_left[3:0];
    grp_pix = '0;
    for (int k = 0; k < 8; k++) begin
      for (int p = 0; p < bpc_pkg::PLANE_COUNT; p++) begin
        // msb of each plane byte is the leftmost pixel
        grp_pix[8*k + p] = (4'(k) < grp_cnt) ? rd_data_q[p][7-k] : 1'b0;
      end
    end
    grp_last = ((RW'(grp_q) + RW'(1)) == ngroups);
  end

  // next-state logic
  logic          in_take;
  logic          slot_free;
  logic          load_err;
  logic [1:0]    err_band;
  logic          put_req;
  logic [7:0]    put_val;
  logic [7:0]    put_rem;
  phase_e        c_phase;
  logic [7:0]    c_run;
  logic [PW-1:0] c_plane;
  logic [AW-1:0] c_bp;
  logic [1:0]    c_band;
  logic          c_err;
  logic [8:0]    run_len;
  logic [RW-1:0] left;
  logic [RW:0]   bp_inc;
  logic [1:0]    band_inc;

  always_comb begin
    width_d = width_q;
    deep_d  = deep_q;
    comp_d  = comp_q;
    state_d = state_q;
    phase_d = phase_q;
    run_d   = run_q;
    plane_d = plane_q;
    bp_d    = bp_q;
    band_d  = band_q;
    err_d   = err_q;
    rem_d   = rem_q;
    byte_d  = byte_q;
    ret_run_d = ret_run_q;
    ebnd_d  = ebnd_q;
    grp_d   = grp_q;
    out_valid_d = out_valid_q;
    pix_d   = pix_q;
    gidx_d  = gidx_q;
    cnt_d   = cnt_q;
    oband_d = oband_q;
    last_d  = last_q;
    derr_d  = derr_q;

    mem_we    = 1'b0;
    mem_addr  = bp_q;
    mem_lane  = plane_q;
    mem_wdata = byte_q;
    rd_en     = 1'b0;
    rd_addr   = grp_q;

    load_err = 1'b0;
    err_band = band_q;
    put_req  = 1'b0;
    put_val  = byte_q;
    put_rem  = 8'd0;
    c_phase  = phase_q;
    c_run    = run_q;
    c_plane  = plane_q;
    c_bp     = bp_q;
    c_band   = band_q;
    c_err    = err_q;
    run_len  = 9'd0;
    left     = '0;
    bp_inc   = '0;
    band_inc = 2'd0;

    in_take   = in_valid_i && (state_q == S_IDLE);
    slot_free = !out_valid_q || out_ready_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        bpc_pkg::CFG_IMAGE_WIDTH: width_d = cfg_data_i;
        bpc_pkg::CFG_DEEP_COLOR:  deep_d  = cfg_data_i[0];
        bpc_pkg::CFG_COMPRESSED:  comp_d  = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (start_image_i) begin
            c_phase = PH_CONTROL;
            c_run   = 8'd0;
            c_plane = '0;
            c_bp    = '0;
            c_band  = 2'd0;
            c_err   = 1'b0;
          end
          phase_d = c_phase;
          run_d   = c_run;
          plane_d = c_plane;
          bp_d    = c_bp;
          band_d  = c_band;
          err_d   = c_err;
          err_band = c_band;
          if (c_err) begin
            // sticky error: every byte answers with one error word
            if (slot_free) begin
              load_err = 1'b1;
            end else begin
              ebnd_d  = c_band;
              state_d = S_ERR;
            end
          end else if (!comp_q) begin
            put_req = 1'b1;
            put_val = data_byte_i;
          end else begin
            case (c_phase)
              PH_LITERAL: begin
                put_req = 1'b1;
                put_val = data_byte_i;
                run_d   = c_run - 8'd1;
                if (c_run == 8'd1) begin
                  phase_d = PH_CONTROL;
                end
              end
              PH_REPEAT: begin
                run_d   = 8'd0;
                phase_d = PH_CONTROL;
                if (c_run != 8'd0) begin
                  put_req = 1'b1;
                  put_val = data_byte_i;
                  put_rem = c_run - 8'd1;
                  rem_d   = c_run - 8'd1;
                  byte_d  = data_byte_i;
                  if (c_run != 8'd1) begin
                    state_d = S_RUN;
                  end
                end
              end
              default: begin
                // control byte
                if (!data_byte_i[7]) begin
                  run_len = {1'b0, data_byte_i} + 9'd1;
                end else begin
                  run_len = 9'd257 - {1'b0, data_byte_i};
                end
                left = (RW'(c_bp) < rs) ? (rs - RW'(c_bp)) : '0;
                if (run_len > 9'(left)) begin
                  err_d   = 1'b1;
                  phase_d = PH_CONTROL;
                  run_d   = 8'd0;
                  if (slot_free) begin
                    load_err = 1'b1;
                  end else begin
                    ebnd_d  = c_band;
                    state_d = S_ERR;
                  end
                end else begin
                  run_d   = run_len[7:0];
                  phase_d = data_byte_i[7] ? PH_REPEAT : PH_LITERAL;
                end
              end
            endcase
          end
        end
      end
      S_RUN: begin
        put_req = 1'b1;
        put_val = byte_q;
        put_rem = rem_q - 8'd1;
        rem_d   = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        err_band = ebnd_q;
        if (slot_free) begin
          load_err = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = grp_q;
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          pix_d   = grp_pix;
          gidx_d  = 6'(grp_q);
          cnt_d   = grp_cnt;
          oband_d = ebnd_q;
          last_d  = grp_last;
          derr_d  = 1'b0;
          if (grp_last) begin
            state_d = ret_run_q ? S_RUN : S_IDLE;
          end else begin
            grp_d   = grp_q + AW'(1);
            rd_en   = 1'b1;
            rd_addr = grp_q + AW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_err) begin
      out_valid_d = 1'b1;
      pix_d   = '0;
      gidx_d  = 6'd0;
      cnt_d   = 4'd0;
      oband_d = err_band;
      last_d  = 1'b0;
      derr_d  = 1'b1;
    end

    // store one byte and advance the plane position
    if (put_req) begin
      mem_we    = 1'b1;
      mem_addr  = c_bp;
      mem_lane  = c_plane;
      mem_wdata = put_val;
      bp_inc    = (RW + 1)'(c_bp) + (RW + 1)'(1);
      if (bp_inc >= (RW + 1)'(rs)) begin
        bp_d = '0;
        if (c_plane == PW'(bpc_pkg::PLANE_COUNT - 1)) begin
          plane_d  = '0;
          band_inc = c_band + 2'd1;
          band_d   = (band_inc >= bcnt) ? 2'd0 : band_inc;
          // a repeat that completes a later band as well only shows that one
          if ((RW + 3)'(put_rem) < {rs, 3'b000}) begin
            state_d   = S_EMIT_RD;
            grp_d     = '0;
            ebnd_d    = c_band;
            ret_run_d = (put_rem != 8'd0);
          end
        end else begin
          plane_d = c_plane + PW'(1);
        end
      end else begin
        bp_d = bp_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 10'(bpc_pkg::MAX_WIDTH);
      deep_q      <= 1'b0;
      comp_q      <= 1'b1;
      state_q     <= S_IDLE;
      phase_q     <= PH_CONTROL;
      run_q       <= 8'd0;
      plane_q     <= '0;
      bp_q        <= '0;
      band_q      <= 2'd0;
      err_q       <= 1'b0;
      rem_q       <= 8'd0;
      byte_q      <= 8'd0;
      ret_run_q   <= 1'b0;
      ebnd_q      <= 2'd0;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
      pix_q       <= '0;
      gidx_q      <= 6'd0;
      cnt_q       <= 4'd0;
      oband_q     <= 2'd0;
      last_q      <= 1'b0;
      derr_q      <= 1'b0;
    end else begin
      width_q     <= width_d;
      deep_q      <= deep_d;
      comp_q      <= comp_d;
      state_q     <= state_d;
      phase_q     <= phase_d;
      run_q       <= run_d;
      plane_q     <= plane_d;
      bp_q        <= bp_d;
      band_q      <= band_d;
      err_q       <= err_d;
      rem_q       <= rem_d;
      byte_q      <= byte_d;
      ret_run_q   <= ret_run_d;
      ebnd_q      <= ebnd_d;
      grp_q       <= grp_d;
      out_valid_q <= out_valid_d;
      pix_q       <= pix_d;
      gidx_q      <= gidx_d;
      cnt_q       <= cnt_d;
      oband_q     <= oband_d;
      last_q      <= last_d;
      derr_q      <= derr_d;
    end
  end

  // plane store, byte-lane write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr][mem_lane] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pixel_group_o  = pix_q;
  assign group_index_o  = gidx_q;
  assign pixel_count_o  = cnt_q;
  assign band_index_o   = oband_q;
  assign last_in_row_o  = last_q;
  assign decode_error_o = derr_q;

endmodule

>>> rtl/core/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks of the byterun1 planar-to-chunky decoder
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic [bpc_pkg::CFG_IW-1:0] cfg_index_i,
  input logic [bpc_pkg::CFG_DW-1:0] cfg_data_i,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [7:0]                 data_byte_i,
  input logic                       start_image_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [63:0]                pixel_group_o,
  input logic [5:0]                 group_index_o,
  input logic [3:0]                 pixel_count_o,
  input logic [1:0]                 band_index_o,
  input logic                       last_in_row_o,
  input logic                       decode_error_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_group_o)
      && $stable(group_index_o) && $stable(band_index_o) && $stable(decode_error_o))
    else $error("stalled output word changed");

  // error word carries no pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> pixel_count_o == 4'd0 && group_index_o == 6'd0
      && !last_in_row_o && pixel_group_o == 64'd0)
    else $error("error word with pixel content");

  // pixel word holds one to eight pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !decode_error_o |-> pixel_count_o != 4'd0 && pixel_count_o <= 4'd8)
    else $error("pixel count out of range");

  // a short group only closes a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !decode_error_o && pixel_count_o != 4'd8 |-> last_in_row_o)
    else $error("short group not marked last");

endmodule

bind byterun1_planar_to_chunky_decoder_top bpc_checker u_bpc_checker (.*);
